>>> hw/rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Types and constants shared by the meter frame deframer and its interfaces.
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int PAYLOAD_BYTES = 20;
	localparam int POS_W         = 5;
	localparam int ADDR_W        = 2;
	localparam int DATA_W        = 32;

	localparam logic [7:0]        SYNC_RESET = 8'hAA;
	localparam logic [ADDR_W-1:0] ADDR_SYNC  = 2'd0;

	localparam logic [POS_W-1:0] POS_FIRST = 5'd1;
	localparam logic [POS_W-1:0] POS_LAST  = 5'd20;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [15:0]        offset_raw;
		logic [7:0]         level_raw;
		logic [15:0]        freq_mantissa;
		logic [7:0]         freq_exponent;
		logic [7:0]         flag_bits;
		logic [31:0]        setup_codes;
		logic [23:0]        second_mantissa;
		logic signed [7:0]  second_exponent;
		logic [23:0]        prime_mantissa;
		logic signed [7:0]  prime_exponent;
		logic [7:0]         change_marker;
		logic               frame_good;
	} mfd_frame_t;

endpackage

>>> hw/rtl/mfd_byte_if.sv
// ----------------------------------------------------------------------------
// mfd_byte_if
// Request channel carrying one received byte.
// ----------------------------------------------------------------------------
interface mfd_byte_if
	import mfd_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/mfd_frame_if.sv
// ----------------------------------------------------------------------------
// mfd_frame_if
// Request channel carrying one unpacked measurement frame.
// ----------------------------------------------------------------------------
interface mfd_frame_if
	import mfd_pkg::*;
();
	logic       valid;
	logic       ready;
	mfd_frame_t frame;

	modport source (output valid, output frame, input ready);
	modport sink   (input valid, input frame, output ready);
endinterface

>>> hw/rtl/meter_frame_deframer.sv
// ----------------------------------------------------------------------------
// meter_frame_deframer
// Hunts for the sync byte, collects a 22-byte measurement frame and emits its
// unpacked fields with a checksum verdict.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake      Contents
//  rx       in   valid/ready    rx_byte, one received byte
//  frames   out  valid/ready    unpacked frame fields and frame_good
//  APB      in   psel/penable   sync_value at address 0
//
//  One byte is accepted every cycle unless the input stalls as described
//  below; a frame result passes from the input register, holding its checksum
//  byte, into the result register, from which it is offered on frames.
//  Reset clears the hunt state, the counter and the sum, and restores the
//  sync value to 0xAA.
//  Input requests stall only when a checksum byte waits in the input register
//  while the result register is still full and not being taken.
// ----------------------------------------------------------------------------
module meter_frame_deframer
	import mfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	mfd_byte_if.sink          rx,
	mfd_frame_if.source       frames
);

	logic             sync_wr;
	byte_t            sync_value_q;
	logic             valid_s1;
	byte_t            byte_s1;
	logic             collecting_q;
	logic [POS_W-1:0] pos_q;
	byte_t            sum_q;
	byte_t            store_q [PAYLOAD_BYTES];
	logic             out_valid_q;
	mfd_frame_t       frame_q;

	logic             is_payload;
	logic             is_chk;
	logic             advance;
	logic             step;
	logic             load;
	logic [POS_W-1:0] store_idx;
	mfd_frame_t       frame_d;

	assign pready  = 1'b1;
	assign sync_wr = psel && penable && pwrite && (paddr == ADDR_SYNC);

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_SYNC) begin
			prdata = {{(DATA_W-8){1'b0}}, sync_value_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= SYNC_RESET;
		end else if (sync_wr) begin
			sync_value_q <= pwdata[7:0];
		end
	end

	assign is_payload = collecting_q && (pos_q >= POS_FIRST) && (pos_q <= POS_LAST);
	assign is_chk     = collecting_q && !is_payload;
	assign advance    = !(is_chk && out_valid_q && !frames.ready);
	assign step       = valid_s1 && advance;
	assign load       = step && is_chk;
	assign rx.ready   = !valid_s1 || advance;
	assign store_idx  = pos_q - POS_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			pos_q        <= '0;
			sum_q        <= '0;
		end else if (step) begin
			if (!collecting_q) begin
				if (byte_s1 == sync_value_q) begin
					collecting_q <= 1'b1;
					pos_q        <= POS_FIRST;
					sum_q        <= byte_s1;
				end
			end else if (is_payload) begin
				pos_q <= pos_q + POS_FIRST;
				sum_q <= sum_q + byte_s1;
			end else begin
				collecting_q <= 1'b0;
				pos_q        <= '0;
				sum_q        <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_payload) begin
			store_q[store_idx] <= byte_s1;
		end
	end

	always_comb begin
		frame_d.offset_raw      = {store_q[1], store_q[0]};
		frame_d.level_raw       = store_q[2];
		frame_d.freq_mantissa   = {store_q[4], store_q[3]};
		frame_d.freq_exponent   = store_q[5];
		frame_d.flag_bits       = store_q[6];
		frame_d.setup_codes     = {store_q[7], store_q[8], store_q[9], store_q[10]};
		frame_d.second_mantissa = {store_q[13], store_q[12], store_q[11]};
		frame_d.second_exponent = $signed(store_q[14]);
		frame_d.prime_mantissa  = {store_q[17], store_q[16], store_q[15]};
		frame_d.prime_exponent  = $signed(store_q[18]);
		frame_d.change_marker   = store_q[19];
		frame_d.frame_good      = (byte_s1 == sum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame_d;
		end
	end

	assign frames.valid = out_valid_q;
	assign frames.frame = frame_q;

`ifndef SYNTHESIS
	a_result_from_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && is_chk))
		else $error("result raised without a checksum byte");

	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> (pos_q >= POS_FIRST) && (pos_q <= POS_LAST + POS_FIRST))
		else $error("byte position out of range while collecting");

	a_hunt_position: assert property (@(posedge clk) disable iff (!arst_n)
		!collecting_q |-> (pos_q == '0) && (sum_q == '0))
		else $error("position or sum not cleared while hunting");

	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !collecting_q && out_valid_q)
		else $error("checksum byte did not end the frame");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> out_valid_q && !frames.ready && is_chk)
		else $error("input stalled with room in the result register");
`endif

endmodule

>>> sim/tb_meter_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_meter_frame_deframer
// Self-checking testbench for the meter frame deframer. A short table of
// bytes covers hunting noise, a sync value inside a frame and a bad checksum,
// then random phases send mostly well-formed frames with random content, plus
// noise and cut-short frames, under several sync values. Both request
// channels idle at random. Every frame request is checked field by field
// against a predictor of the deframer kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_meter_frame_deframer;
	import mfd_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int ITEM_TARGET   = 1700;
	localparam int NUM_PHASES    = 8;
	localparam int SETTLE_CYCLES = 6;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		byte_t      rx;
		logic       typed;
		mfd_frame_t frame;
	} byte_row_t;

	localparam mfd_frame_t ONES_BAD_SUM = '{
		offset_raw: 16'hFFFF, level_raw: 8'hFF, freq_mantissa: 16'hFFFF,
		freq_exponent: 8'hFF, flag_bits: 8'hFF, setup_codes: 32'hFFFF_FFFF,
		second_mantissa: 24'hFF_FFFF, second_exponent: -8'sd1,
		prime_mantissa: 24'hFF_FFFF, prime_exponent: -8'sd1,
		change_marker: 8'hAA, frame_good: 1'b0};

	localparam byte_row_t BYTE_TABLE [0:23] = '{
		'{8'h00, 1'b0, '0},
		'{8'h55, 1'b0, '0},
		'{8'hAA, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hAA, 1'b0, '0},
		'{8'h40, 1'b1, ONES_BAD_SUM}
	};

	localparam byte_t SYNC_PLAN [0:NUM_PHASES-1] = '{
		8'h00, 8'hFF, 8'h5A, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hC3};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mfd_byte_if  rx_ch ();
	mfd_frame_if frame_ch ();

	meter_frame_deframer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.frames  (frame_ch)
	);

	byte_t      sync_reg = SYNC_RESET;
	bit         in_frame = 1'b0;
	logic [4:0] frame_pos = '0;
	byte_t      frame_sum = '0;
	byte_t      frame_store [1:PAYLOAD_BYTES];
	bit         byte_taken;

	mfd_frame_t expected_frames [$];
	int         mismatches = 0;
	int         taken_bytes = 0;
	int         cycle_count = 0;
	bit         quiet = 1'b0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[meter_frame_deframer] ERROR");
			$finish;
		end
	end

	function automatic int idle_cycles();
		return quiet ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic byte_t payload_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return sync_reg;
			default: return byte_t'($urandom);
		endcase
	endfunction

	// Advances the deframer state by one byte; returns 1 when a frame is due.
	function automatic bit deframe_byte(input byte_t b, output mfd_frame_t f);
		f = '0;
		if (!in_frame) begin
			byte_taken = (b == sync_reg);
			if (byte_taken) begin
				in_frame  = 1'b1;
				frame_pos = POS_FIRST;
				frame_sum = b;
			end
			return 1'b0;
		end
		byte_taken = 1'b1;
		if (frame_pos >= POS_FIRST && frame_pos <= POS_LAST) begin
			frame_store[frame_pos] = b;
			frame_sum = frame_sum + b;
			frame_pos = frame_pos + 5'd1;
			return 1'b0;
		end
		f.offset_raw      = {frame_store[2], frame_store[1]};
		f.level_raw       = frame_store[3];
		f.freq_mantissa   = {frame_store[5], frame_store[4]};
		f.freq_exponent   = frame_store[6];
		f.flag_bits       = frame_store[7];
		f.setup_codes     = {frame_store[8], frame_store[9], frame_store[10], frame_store[11]};
		f.second_mantissa = {frame_store[14], frame_store[13], frame_store[12]};
		f.second_exponent = frame_store[15];
		f.prime_mantissa  = {frame_store[18], frame_store[17], frame_store[16]};
		f.prime_exponent  = frame_store[19];
		f.change_marker   = frame_store[20];
		f.frame_good      = (b == frame_sum);
		in_frame  = 1'b0;
		frame_pos = '0;
		frame_sum = '0;
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s expected %h, got %h", name, want, got));
	endtask

	task automatic send_byte(input byte_t b);
		int         gap;
		mfd_frame_t f;
		gap = idle_cycles();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		if (deframe_byte(b, f))
			expected_frames = {expected_frames, f};
		if (byte_taken)
			taken_bytes++;
	endtask

	task automatic send_partial_frame();
		send_byte(sync_reg);
		repeat ($urandom_range(0, PAYLOAD_BYTES - 1)) send_byte(payload_byte());
	endtask

	task automatic send_sequence();
		int    kind;
		byte_t sum;
		byte_t b;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			sum = sync_reg;
			send_byte(sync_reg);
			repeat (PAYLOAD_BYTES) begin
				b = payload_byte();
				sum = sum + b;
				send_byte(b);
			end
			if ($urandom_range(0, 3) == 0)
				sum = sum + byte_t'($urandom_range(1, 255));
			send_byte(sum);
		end else if (kind < 9) begin
			repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom));
		end else begin
			send_partial_frame();
		end
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_SYNC)
			sync_reg = data[7:0];
	endtask

	task automatic apb_check_sync();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_SYNC;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("sync_value", prdata, {24'd0, sync_reg});
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : frame_sink
		int stall;
		frame_ch.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				frame_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frame_ch.ready <= 1'b1;
			do @(posedge clk); while (!frame_ch.valid);
		end
	end

	always @(posedge clk) begin : frame_check
		mfd_frame_t want;
		mfd_frame_t got;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			got = frame_ch.frame;
			if (expected_frames.size() == 0) begin
				note_mismatch($sformatf("unexpected frame %h", got));
			end else begin
				want = expected_frames.pop_front();
				check_field("offset_raw", 32'(got.offset_raw), 32'(want.offset_raw));
				check_field("level_raw", 32'(got.level_raw), 32'(want.level_raw));
				check_field("freq_mantissa", 32'(got.freq_mantissa),
					32'(want.freq_mantissa));
				check_field("freq_exponent", 32'(got.freq_exponent),
					32'(want.freq_exponent));
				check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
				check_field("setup_codes", got.setup_codes, want.setup_codes);
				check_field("second_mantissa", 32'(got.second_mantissa),
					32'(want.second_mantissa));
				check_field("second_exponent", 32'($unsigned(got.second_exponent)),
					32'($unsigned(want.second_exponent)));
				check_field("prime_mantissa", 32'(got.prime_mantissa),
					32'(want.prime_mantissa));
				check_field("prime_exponent", 32'($unsigned(got.prime_exponent)),
					32'($unsigned(want.prime_exponent)));
				check_field("change_marker", 32'(got.change_marker),
					32'(want.change_marker));
				check_field("frame_good", 32'(got.frame_good), 32'(want.frame_good));
			end
		end
	end

	initial begin : stimulus
		int    phase;
		byte_t sync_next;
		foreach (frame_store[i])
			frame_store[i] = '0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_check_sync();
		foreach (BYTE_TABLE[i]) begin
			send_byte(BYTE_TABLE[i].rx);
			if (BYTE_TABLE[i].typed)
				expected_frames[$] = BYTE_TABLE[i].frame;
		end
		settle();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			quiet = (phase % 3 == 2);
			sync_next = (phase == 4) ? byte_t'($urandom) : SYNC_PLAN[phase];
			apb_write(ADDR_SYNC, {24'($urandom), sync_next});
			@(posedge clk);
			apb_check_sync();
			while (taken_bytes < (phase + 1) * ITEM_TARGET / NUM_PHASES)
				send_sequence();
			if (phase % 2 == 1)
				send_partial_frame();
			settle();
		end

		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("[meter_frame_deframer] OK");
		end else begin
			$display("[meter_frame_deframer] ERROR");
		end
		$finish;
	end

endmodule
